### design/bc1d_pkg.sv
// shared types and constants for the bc1 block decoder
// no dependencies; imported by the palette, serializer and top level modules
`default_nettype none

package bc1d_pkg;

    localparam int unsigned PIXELS = 16;
    localparam int unsigned IDX_W  = 4;
    localparam int unsigned SEL_W  = 2 * PIXELS;

    // palette entry codes carried by the selector bits
    localparam logic [1:0] SEL_C0   = 2'd0;
    localparam logic [1:0] SEL_C1   = 2'd1;
    localparam logic [1:0] SEL_MID  = 2'd2;
    localparam logic [1:0] SEL_LAST = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

    typedef logic [7:0] chan_t;

    // one finished palette plus the selectors of its block
    typedef struct packed {
        chan_t [3:0]        red;
        chan_t [3:0]        green;
        chan_t [3:0]        blue;
        logic               four_color;
        logic [SEL_W-1:0]   selector_bits;
    } palette_t;

endpackage

`default_nettype wire

### design/bc1d_palette.sv
// three-stage palette builder: expand, endpoint sums, divide and select
// depends on bc1d_pkg
`default_nettype none

module bc1d_palette (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [15:0]            first_color,
    input  wire logic [15:0]            second_color,
    input  wire logic [bc1d_pkg::SEL_W-1:0] selector_bits,
    output logic                        pal_valid,
    input  wire logic                   pal_ready,
    output bc1d_pkg::palette_t          pal
);
    import bc1d_pkg::*;

    // truncating divide by three for sums up to 765
    function automatic chan_t div3(input logic [9:0] x);
        logic [20:0] prod;
        prod = 21'(x) * 21'd683;
        return prod[18:11];
    endfunction

    // stage a: expanded endpoints
    logic             a_valid_reg;
    chan_t [2:0]      a_e0_reg;
    chan_t [2:0]      a_e1_reg;
    logic             a_four_reg;
    logic [SEL_W-1:0] a_sel_reg;

    // stage b: endpoint sums
    logic             b_valid_reg;
    chan_t [2:0]      b_e0_reg;
    chan_t [2:0]      b_e1_reg;
    logic [2:0][9:0]  b_two_one_reg;
    logic [2:0][9:0]  b_one_two_reg;
    logic [2:0][8:0]  b_pair_reg;
    logic             b_four_reg;
    logic [SEL_W-1:0] b_sel_reg;

    // stage c: finished palette
    logic             c_valid_reg;
    palette_t         c_pal_reg;

    logic a_ready, b_ready, c_ready;
    chan_t [2:0] e0, e1;
    palette_t c_pal_next;

    assign c_ready  = !c_valid_reg || pal_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // rgb565 to rgb888 by bit replication
    assign e0[0] = {first_color[15:11], first_color[15:13]};
    assign e0[1] = {first_color[10:5],  first_color[10:9]};
    assign e0[2] = {first_color[4:0],   first_color[4:2]};
    assign e1[0] = {second_color[15:11], second_color[15:13]};
    assign e1[1] = {second_color[10:5],  second_color[10:9]};
    assign e1[2] = {second_color[4:0],   second_color[4:2]};

    always_comb begin
        chan_t [2:0] mid;
        chan_t [2:0] last;
        for (int ch = 0; ch < 3; ch++) begin
            if (b_four_reg) begin
                mid[ch]  = div3(b_two_one_reg[ch]);
                last[ch] = div3(b_one_two_reg[ch]);
            end else begin
                mid[ch]  = b_pair_reg[ch][8:1];
                last[ch] = 8'd0;
            end
        end
        c_pal_next.red           = {last[0], mid[0], b_e1_reg[0], b_e0_reg[0]};
        c_pal_next.green         = {last[1], mid[1], b_e1_reg[1], b_e0_reg[1]};
        c_pal_next.blue          = {last[2], mid[2], b_e1_reg[2], b_e0_reg[2]};
        c_pal_next.four_color    = b_four_reg;
        c_pal_next.selector_bits = b_sel_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) a_valid_reg <= in_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
            if (c_ready) c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_e0_reg   <= e0;
            a_e1_reg   <= e1;
            a_four_reg <= first_color > second_color;
            a_sel_reg  <= selector_bits;
        end
        if (b_ready && a_valid_reg) begin
            b_e0_reg   <= a_e0_reg;
            b_e1_reg   <= a_e1_reg;
            b_four_reg <= a_four_reg;
            b_sel_reg  <= a_sel_reg;
            for (int ch = 0; ch < 3; ch++) begin
                b_two_one_reg[ch] <= {1'b0, a_e0_reg[ch], 1'b0} + 10'(a_e1_reg[ch]);
                b_one_two_reg[ch] <= 10'(a_e0_reg[ch]) + {1'b0, a_e1_reg[ch], 1'b0};
                b_pair_reg[ch]    <= 9'(a_e0_reg[ch]) + 9'(a_e1_reg[ch]);
            end
        end
        if (c_ready && b_valid_reg) begin
            c_pal_reg <= c_pal_next;
        end
    end

    assign pal_valid = c_valid_reg;
    assign pal       = c_pal_reg;

endmodule

`default_nettype wire

### design/bc1d_serializer.sv
// walks one palette over sixteen pixels into a registered output word
// depends on bc1d_pkg
`default_nettype none

module bc1d_serializer (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       pal_valid,
    output logic                            pal_ready,
    input  wire bc1d_pkg::palette_t         pal,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output bc1d_pkg::chan_t                 out_red,
    output bc1d_pkg::chan_t                 out_green,
    output bc1d_pkg::chan_t                 out_blue,
    output bc1d_pkg::chan_t                 out_alpha,
    output logic [bc1d_pkg::IDX_W-1:0]      out_pixel_index,
    output logic                            out_last_pixel
);
    import bc1d_pkg::*;

    logic             busy_reg;
    logic [IDX_W-1:0] cnt_reg;
    palette_t         blk_reg;

    logic             out_valid_reg;
    chan_t            red_reg, green_reg, blue_reg, alpha_reg;
    logic [IDX_W-1:0] index_reg;
    logic             last_reg;

    logic out_adv, emit, done, load, is_last;
    logic [1:0] sel;

    assign out_adv   = !out_valid_reg || out_ready;
    assign emit      = busy_reg && out_adv;
    assign is_last   = cnt_reg == IDX_W'(PIXELS - 1);
    assign done      = emit && is_last;
    assign pal_ready = !busy_reg || done;
    assign load      = pal_valid && pal_ready;
    assign sel       = blk_reg.selector_bits[{cnt_reg, 1'b0} +: 2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (done) begin
                busy_reg <= 1'b0;
            end else if (emit) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (out_adv) out_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) blk_reg <= pal;
        if (emit) begin
            red_reg   <= blk_reg.red[sel];
            green_reg <= blk_reg.green[sel];
            blue_reg  <= blk_reg.blue[sel];
            // transparent entry only in three-color mode
            alpha_reg <= (sel == SEL_LAST && !blk_reg.four_color) ? ALPHA_CLEAR
                                                                  : ALPHA_OPAQUE;
            index_reg <= cnt_reg;
            last_reg  <= is_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_red         = red_reg;
    assign out_green       = green_reg;
    assign out_blue        = blue_reg;
    assign out_alpha       = alpha_reg;
    assign out_pixel_index = index_reg;
    assign out_last_pixel  = last_reg;

endmodule

`default_nettype wire

### design/bc1_block_decoder_core.sv
// path: first pixel of a block passes palette stages a, b, c, the serializer's
//   palette register and output register; throughput: one pixel word per cycle
//   when the output never stalls; the 16-pixel walk in the serializer sets this
// three palette stages buffer up to three more blocks while one is walked
// reset: synchronous active-low aresetn clears all valid bits and the pixel walk
// depends on bc1d_pkg, bc1d_palette, bc1d_serializer
`default_nettype none

module bc1_block_decoder_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // block words in
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [15:0]                s_first_color,
    input  wire logic [15:0]                s_second_color,
    input  wire logic [bc1d_pkg::SEL_W-1:0] s_selector_bits,
    // pixel words out
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [7:0]                      m_red,
    output logic [7:0]                      m_green,
    output logic [7:0]                      m_blue,
    output logic [7:0]                      m_alpha,
    output logic [bc1d_pkg::IDX_W-1:0]      m_pixel_index,
    output logic                            m_last_pixel
);
    import bc1d_pkg::*;

    // palette handoff between builder and pixel walker
    logic     pal_valid;
    logic     pal_ready;
    palette_t pal;

    // expand endpoints, form sums, divide by three and pick the mode entries
    bc1d_palette u_palette (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .first_color   (s_first_color),
        .second_color  (s_second_color),
        .selector_bits (s_selector_bits),
        .pal_valid     (pal_valid),
        .pal_ready     (pal_ready),
        .pal           (pal)
    );

    // walk the sixteen selectors, one pixel word per cycle while the output is not stalled
    // the next palette loads on the cycle the last pixel leaves, so blocks abut
    bc1d_serializer u_serializer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pal_valid       (pal_valid),
        .pal_ready       (pal_ready),
        .pal             (pal),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .out_red         (m_red),
        .out_green       (m_green),
        .out_blue        (m_blue),
        .out_alpha       (m_alpha),
        .out_pixel_index (m_pixel_index),
        .out_last_pixel  (m_last_pixel)
    );

endmodule

`default_nettype wire

### design/bc1d_checker.sv
// port-level checks for the bc1 block decoder, bound to the top level
// depends on bc1d_pkg and bc1_block_decoder_core
`default_nettype none

module bc1d_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [7:0]                 m_red,
    input wire logic [7:0]                 m_green,
    input wire logic [7:0]                 m_blue,
    input wire logic [7:0]                 m_alpha,
    input wire logic [bc1d_pkg::IDX_W-1:0] m_pixel_index,
    input wire logic                       m_last_pixel
);
    import bc1d_pkg::*;

    // no pixel word right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("pixel word valid after reset");

    // last flag marks exactly the sixteenth pixel
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_pixel == (m_pixel_index == IDX_W'(PIXELS - 1))))
        else $error("last flag does not match pixel index");

    // within a block the next pixel follows at once with the next index
    a_pixel_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_pixel) |=>
            (m_valid && m_pixel_index == IDX_W'($past(m_pixel_index) + 1'b1)))
        else $error("pixel sequence broken inside a block");

    // a non-opaque pixel is always transparent black
    a_clear_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_alpha != ALPHA_OPAQUE) |->
            (m_alpha == ALPHA_CLEAR && m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0))
        else $error("transparent pixel not black");

    // stalled word holds its red, alpha and pixel index
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_red) && $stable(m_pixel_index) && $stable(m_alpha)))
        else $error("stalled pixel word changed");

endmodule

bind bc1_block_decoder_core bc1d_checker u_bc1d_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_red         (m_red),
    .m_green       (m_green),
    .m_blue        (m_blue),
    .m_alpha       (m_alpha),
    .m_pixel_index (m_pixel_index),
    .m_last_pixel  (m_last_pixel)
);

`default_nettype wire
